/* rtl/assert_macros.svh */
// Assertion macros shared by the line-of-sight RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, held off during reset.
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off during reset.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

/* rtl/glos_pkg.sv */
// Shared types and constants for the grid line-of-sight block.
package glos_pkg;

    localparam int DEF_MAX_WIDTH  = 64;
    localparam int DEF_MAX_HEIGHT = 64;

    localparam int COORD_W   = 6;   // cell coordinate on the ports
    localparam int GRID_W    = 7;   // grid size registers
    localparam int POS_W     = 7;   // walk position registers
    localparam int ERR_W     = 10;  // doubled Bresenham error, signed
    localparam int CFG_IDX_W = 1;
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 1'b1;

    localparam logic [GRID_W-1:0] GRID_SIZE_RESET = 7'd64;

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    localparam logic STATUS_DONE    = 1'b0;
    localparam logic STATUS_OUTSIDE = 1'b1;

    typedef struct packed {
        logic               outside;
        logic [COORD_W-1:0] sx;
        logic [COORD_W-1:0] sy;
        logic [COORD_W-1:0] gx;
        logic [COORD_W-1:0] gy;
    } glos_query_t;

    typedef struct packed {
        logic visible;
        logic status;
    } glos_result_t;

endpackage

/* rtl/glos_map.sv */
// Obstacle bitmap: one row per word, cleared row by row after reset.
module glos_map
    import glos_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
    localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          wr_en,
    input  logic [RW-1:0] wr_row,
    input  logic [CW-1:0] wr_col,
    input  logic          wr_bit,
    input  logic [RW-1:0] rd_row,
    input  logic [CW-1:0] rd_col,
    output logic          rd_bit,
    output logic          ready
);

    logic [MAX_WIDTH-1:0] mem [MAX_HEIGHT];
    logic [MAX_WIDTH-1:0] row_q_reg;
    logic [CW-1:0]        col_q_reg;
    logic [RW-1:0]        clr_row_reg;
    logic                 clr_busy_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg <= 1'b1;
            clr_row_reg  <= '0;
        end else if (clr_busy_reg) begin
            clr_row_reg <= clr_row_reg + 1'b1;
            if (clr_row_reg == RW'(MAX_HEIGHT - 1)) begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (clr_busy_reg) begin
            mem[clr_row_reg] <= '0;
        end else if (wr_en) begin
            mem[wr_row][wr_col] <= wr_bit;
        end
        row_q_reg <= mem[rd_row];
        col_q_reg <= rd_col;
    end

    assign rd_bit = row_q_reg[col_q_reg];
    assign ready  = !clr_busy_reg;

endmodule

/* rtl/glos_walk.sv */
// Bresenham walk sequencer around one shared error adder.
`include "assert_macros.svh"

module glos_walk
    import glos_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  glos_query_t        query,
    input  logic               rd_bit,
    output logic [COORD_W-1:0] rd_x,
    output logic [COORD_W-1:0] rd_y,
    output logic               idle,
    output logic               res_valid,
    output glos_result_t       res,
    input  logic               res_take
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ISSUE,
        S_CHECK,
        S_CHECK2,
        S_DONE
    } walk_state_t;

    walk_state_t              state_reg, state_next;
    logic [POS_W-1:0]         major_reg, major_next;
    logic [POS_W-1:0]         minor_reg, minor_next;
    logic [POS_W-1:0]         end_reg, end_next;
    logic [COORD_W-1:0]       dx_reg, dx_next;
    logic [COORD_W-1:0]       dy_reg, dy_next;
    logic                     steep_reg, steep_next;
    logic                     up_reg, up_next;
    logic signed [ERR_W-1:0]  err_reg, err_next;
    glos_result_t             res_reg, res_next;

    // setup terms
    logic [COORD_W-1:0] adx, ady, a0, b0, a1, b1, sa0, sb0, sa1, sb1;
    logic               steep, swap;

    // shared error unit
    logic signed [ERR_W-1:0] operand, err_sum, neg_dy;

    always_comb begin
        adx   = (query.sx > query.gx) ? query.sx - query.gx : query.gx - query.sx;
        ady   = (query.sy > query.gy) ? query.sy - query.gy : query.gy - query.sy;
        steep = ady > adx;
        a0    = steep ? query.sy : query.sx;
        b0    = steep ? query.sx : query.sy;
        a1    = steep ? query.gy : query.gx;
        b1    = steep ? query.gx : query.gy;
        swap  = a0 > a1;
        sa0   = swap ? a1 : a0;
        sb0   = swap ? b1 : b0;
        sa1   = swap ? a0 : a1;
        sb1   = swap ? b0 : b1;
    end

    assign neg_dy  = -$signed(ERR_W'(dy_reg));
    assign operand = (state_reg == S_CHECK2) ? $signed(ERR_W'({dx_reg, 1'b0}))
                                             : -$signed(ERR_W'({dy_reg, 1'b0}));
    assign err_sum = err_reg + operand;

    always_comb begin
        state_next = state_reg;
        major_next = major_reg;
        minor_next = minor_reg;
        end_next   = end_reg;
        dx_next    = dx_reg;
        dy_next    = dy_reg;
        steep_next = steep_reg;
        up_next    = up_reg;
        err_next   = err_reg;
        res_next   = res_reg;
        case (state_reg)
            S_IDLE: begin
                if (start) begin
                    if (query.outside) begin
                        res_next.visible = 1'b0;
                        res_next.status  = STATUS_OUTSIDE;
                        state_next       = S_DONE;
                    end else begin
                        major_next = POS_W'(sa0);
                        minor_next = POS_W'(sb0);
                        end_next   = POS_W'(sa1);
                        dx_next    = sa1 - sa0;
                        dy_next    = steep ? adx : ady;
                        steep_next = steep;
                        up_next    = sb0 < sb1;
                        err_next   = $signed(ERR_W'(sa1 - sa0));
                        state_next = S_ISSUE;
                    end
                end
            end
            S_ISSUE: begin
                state_next = S_CHECK;
            end
            S_CHECK: begin
                if (rd_bit) begin
                    res_next.visible = 1'b0;
                    res_next.status  = STATUS_DONE;
                    state_next       = S_DONE;
                end else begin
                    err_next = err_sum;
                    if (err_sum < neg_dy) begin
                        minor_next = up_reg ? minor_reg + 1'b1 : minor_reg - 1'b1;
                        state_next = S_CHECK2;
                    end else if (major_reg == end_reg) begin
                        res_next.visible = 1'b1;
                        res_next.status  = STATUS_DONE;
                        state_next       = S_DONE;
                    end else begin
                        major_next = major_reg + 1'b1;
                    end
                end
            end
            S_CHECK2: begin
                if (rd_bit) begin
                    res_next.visible = 1'b0;
                    res_next.status  = STATUS_DONE;
                    state_next       = S_DONE;
                end else begin
                    err_next = err_sum;
                    if (major_reg == end_reg) begin
                        res_next.visible = 1'b1;
                        res_next.status  = STATUS_DONE;
                        state_next       = S_DONE;
                    end else begin
                        major_next = major_reg + 1'b1;
                        state_next = S_CHECK;
                    end
                end
            end
            S_DONE: begin
                if (res_take) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
        major_reg <= major_next;
        minor_reg <= minor_next;
        end_reg   <= end_next;
        dx_reg    <= dx_next;
        dy_reg    <= dy_next;
        steep_reg <= steep_next;
        up_reg    <= up_next;
        err_reg   <= err_next;
        res_reg   <= res_next;
    end

    // Present the cell of the next check so its map bit is ready the cycle after.
    assign rd_x = steep_next ? COORD_W'(minor_next) : COORD_W'(major_next);
    assign rd_y = steep_next ? COORD_W'(major_next) : COORD_W'(minor_next);

    assign idle      = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign res       = res_reg;

    `ASSERT_IMPLY(a_err_floor, aclk, aresetn, state_reg == S_CHECK, err_reg >= neg_dy,
        "walk error below -dy at a major step")
    `ASSERT_IMPLY(a_major_in_span, aclk, aresetn,
        (state_reg == S_CHECK) || (state_reg == S_CHECK2), major_reg <= end_reg,
        "walk ran past the end of the line")
    `ASSERT_NEXT(a_single_minor_step, aclk, aresetn, state_reg == S_CHECK2,
        state_reg != S_CHECK2, "two minor steps at one major position")
    `ASSERT_IMPLY(a_outside_blocked, aclk, aresetn,
        res_valid && (res.status == STATUS_OUTSIDE), !res.visible,
        "outside query reported visible")

endmodule

/* rtl/grid_line_of_sight.sv */
// Top level: line-of-sight queries over a one-bit obstacle map.
//
// Input words arrive on s_tvalid/s_tready. s_tuser is the kind: a write
// word sets or clears one map cell and yields no result; a query word walks
// a Bresenham line from start to goal and yields one result word on
// m_tvalid/m_tready (m_tdata[0] visible, m_tuser status). A query with an
// endpoint outside the configured grid returns status 1 without a walk. The
// user writes grid width and height on the cfg channel while idle, unenforced.
//
// Flow: writes stream back to back. A query checks the cells of its line,
// the major-axis span plus one plus the number of minor steps; the walk
// checks one cell per cycle, bounded by the single map read port, and no
// new word is accepted until the walk is idle again.
// Reset: the map is cleared one row per cycle, all MAX_HEIGHT rows, with
// s_tready low; cfg writes are taken meanwhile. A stalled result is held in
// the output register; the next word is accepted, and a following result
// waits in the walk unit until the register frees.
module grid_line_of_sight
    import glos_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // [5:0] start_x, [11:6] start_y, [17:12] goal_x, [23:18] goal_y,
    // [24] cell_value, [31:25] zero
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 s_tuser,   // [0] kind
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // [0] visible, [7:1] zero
    output logic                 m_tuser,   // [0] status
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [GRID_W-1:0]    cfg_data
);

    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam logic [10:0] MAX_W_LIM = 11'(MAX_WIDTH);
    localparam logic [10:0] MAX_H_LIM = 11'(MAX_HEIGHT);

    logic [GRID_W-1:0]  width_reg, height_reg;
    logic [COORD_W-1:0] sx, sy, gx, gy;
    logic               cell_value, start_in, goal_in, accept;
    logic               map_ready, walk_idle, rd_bit, res_valid, res_take;
    logic [COORD_W-1:0] rd_x, rd_y;
    glos_query_t        query;
    glos_result_t       res;
    logic               m_valid_reg;
    glos_result_t       m_res_reg;

    function automatic logic in_grid(input logic [COORD_W-1:0] x,
                                     input logic [COORD_W-1:0] y,
                                     input logic [GRID_W-1:0]  w,
                                     input logic [GRID_W-1:0]  h);
        return (GRID_W'(x) < w) && (GRID_W'(y) < h)
            && (11'(x) < MAX_W_LIM) && (11'(y) < MAX_H_LIM);
    endfunction

    assign sx         = s_tdata[5:0];
    assign sy         = s_tdata[11:6];
    assign gx         = s_tdata[17:12];
    assign gy         = s_tdata[23:18];
    assign cell_value = s_tdata[24];

    assign start_in = in_grid(sx, sy, width_reg, height_reg);
    assign goal_in  = in_grid(gx, gy, width_reg, height_reg);

    assign s_tready = map_ready && walk_idle;
    assign accept   = s_tvalid && s_tready;

    assign query.outside = !(start_in && goal_in);
    assign query.sx      = sx;
    assign query.sy      = sy;
    assign query.gx      = gx;
    assign query.gy      = gy;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= GRID_SIZE_RESET;
            height_reg <= GRID_SIZE_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_GRID_WIDTH:  width_reg  <= cfg_data;
                REG_GRID_HEIGHT: height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    glos_map #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_map (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (accept && (s_tuser == KIND_WRITE) && start_in),
        .wr_row  (RW'(sy)),
        .wr_col  (CW'(sx)),
        .wr_bit  (cell_value),
        .rd_row  (RW'(rd_y)),
        .rd_col  (CW'(rd_x)),
        .rd_bit  (rd_bit),
        .ready   (map_ready)
    );

    glos_walk u_walk (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (accept && (s_tuser == KIND_QUERY)),
        .query     (query),
        .rd_bit    (rd_bit),
        .rd_x      (rd_x),
        .rd_y      (rd_y),
        .idle      (walk_idle),
        .res_valid (res_valid),
        .res       (res),
        .res_take  (res_take)
    );

    // Move a finished result into the output register once it frees.
    assign res_take = res_valid && (!m_valid_reg || m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_take) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
        if (res_take) begin
            m_res_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_TDATA_W'(m_res_reg.visible);
    assign m_tuser  = m_res_reg.status;

endmodule
